// ----- rtl/core/mels_pkg.sv -----
package mels_pkg;

  // Prefix sums, run sums and the best result all live in 64-bit two's complement.
  localparam int unsigned SUM_W = 64;

  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Depth of the delay line of earlier prefix sums.
  localparam int unsigned HIST_DEPTH = 4;

  // Element count saturates here; a run of four or more exists from the third old element on.
  localparam logic [2:0] COUNT_SAT = 3'd4;
  localparam logic [2:0] RUN_START = 3'd3;

  // Control bits that travel with an item from stage to stage.
  typedef struct packed {
    logic vld;
    logic last;
    logic use_cand;
  } stage_ctl_t;

endpackage

// ----- rtl/core/mels_prefix.sv -----
module mels_prefix #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  mels_pkg::stage_ctl_t   ctl_in,
  input  logic [VALUE_WIDTH-1:0] value,
  output mels_pkg::stage_ctl_t   ctl_r,
  output mels_pkg::sum_t         sum_r,
  output mels_pkg::sum_t         base_r
);

  mels_pkg::sum_t run_r;
  mels_pkg::sum_t hist_r [mels_pkg::HIST_DEPTH];
  mels_pkg::sum_t min_even_r;
  mels_pkg::sum_t min_odd_r;
  logic [2:0]     cnt_r;
  logic           par_r;

  mels_pkg::sum_t x_ext;
  mels_pkg::sum_t sum_nxt;
  mels_pkg::sum_t oldest;
  mels_pkg::sum_t min_even_nxt;
  mels_pkg::sum_t min_odd_nxt;
  mels_pkg::sum_t base_nxt;
  logic           run_start;
  logic [2:0]     cnt_nxt;

  assign x_ext     = mels_pkg::sum_t'({{(mels_pkg::SUM_W-VALUE_WIDTH){value[VALUE_WIDTH-1]}},
                                       value});
  assign sum_nxt   = run_r + x_ext;
  assign oldest    = hist_r[mels_pkg::HIST_DEPTH-1];
  assign run_start = (cnt_r >= mels_pkg::RUN_START);

  // A run ending at an even index must start at an even index, and likewise for odd.
  assign min_even_nxt = (oldest < min_even_r) ? oldest : min_even_r;
  assign min_odd_nxt  = (oldest < min_odd_r) ? oldest : min_odd_r;
  assign base_nxt     = par_r ? min_even_nxt : min_odd_nxt;
  assign cnt_nxt      = (cnt_r < mels_pkg::COUNT_SAT) ? cnt_r + 3'd1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r      <= '0;
      run_r      <= '0;
      for (int i = 0; i < mels_pkg::HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      min_even_r <= '0;
      min_odd_r  <= mels_pkg::SUM_MAX;
      cnt_r      <= '0;
      par_r      <= 1'b0;
    end else if (adv) begin
      ctl_r.vld      <= ctl_in.vld;
      ctl_r.last     <= ctl_in.last;
      ctl_r.use_cand <= ctl_in.vld & run_start;
      if (ctl_in.vld) begin
        if (ctl_in.last) begin
          // The sequence ends here; start the next one from the reset state.
          run_r      <= '0;
          for (int i = 0; i < mels_pkg::HIST_DEPTH; i++) begin
            hist_r[i] <= '0;
          end
          min_even_r <= '0;
          min_odd_r  <= mels_pkg::SUM_MAX;
          cnt_r      <= '0;
          par_r      <= 1'b0;
        end else begin
          run_r     <= sum_nxt;
          hist_r[0] <= sum_nxt;
          for (int i = 1; i < mels_pkg::HIST_DEPTH; i++) begin
            hist_r[i] <= hist_r[i-1];
          end
          if (run_start) begin
            if (par_r) begin
              min_even_r <= min_even_nxt;
            end else begin
              min_odd_r <= min_odd_nxt;
            end
          end
          cnt_r <= cnt_nxt;
          par_r <= ~par_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_in.vld) begin
      sum_r  <= sum_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

// ----- rtl/core/mels_best.sv -----
module mels_best (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  mels_pkg::stage_ctl_t ctl,
  input  mels_pkg::sum_t       cand,
  input  logic                 out_stall,
  output logic                 out_valid,
  output mels_pkg::sum_t       out_best_sum,
  output logic                 out_found
);

  mels_pkg::sum_t best_r;
  logic           bvalid_r;
  logic           out_valid_r;
  mels_pkg::sum_t out_sum_r;
  logic           out_found_r;

  mels_pkg::sum_t best_nxt;
  logic           bvalid_nxt;
  logic           load;

  assign best_nxt   = (ctl.use_cand && (!bvalid_r || (best_r < cand))) ? cand : best_r;
  assign bvalid_nxt = bvalid_r | ctl.use_cand;
  assign load       = adv & ctl.vld & ctl.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= mels_pkg::SUM_MIN;
      bvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv && ctl.vld) begin
        if (ctl.last) begin
          best_r   <= mels_pkg::SUM_MIN;
          bvalid_r <= 1'b0;
        end else begin
          best_r   <= best_nxt;
          bvalid_r <= bvalid_nxt;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sum_r   <= bvalid_nxt ? best_nxt : '0;
      out_found_r <= bvalid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_best_sum = out_sum_r;
  assign out_found    = out_found_r;

endmodule

// ----- rtl/core/max_even_length_subarray_sum.sv -----
// Channel  Dir  Ports                                       Request
// in       in   in_valid in_stall in_value in_last          one element of the sequence
// out      out  out_valid out_stall out_best_sum out_found  one result per sequence
//
// One request is taken in every cycle that the pipeline is not held; a result
// appears after the request marked last has passed the subtract stage.
// The pipeline is input register, prefix unit, subtract stage and best-sum unit
// with its output register; the 64-bit prefix add sets the cycle time.
// Reset is synchronous on rst_n and returns every stage to the start of a sequence.
// in_stall rises only while a finished result waits under out_stall and another
// result is about to reach the output register.
module max_even_length_subarray_sum #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [63:0]     out_best_sum,
  output logic                   out_found
);

  // Stage 0: registered request.
  mels_pkg::stage_ctl_t   s0_ctl_r;
  logic [VALUE_WIDTH-1:0] s0_value_r;

  // Stage 1: new prefix sum and the smallest usable earlier prefix sum.
  mels_pkg::stage_ctl_t s1_ctl;
  mels_pkg::sum_t       s1_sum;
  mels_pkg::sum_t       s1_base;

  // Stage 2: candidate run sum.
  mels_pkg::stage_ctl_t s2_ctl_r;
  mels_pkg::sum_t       s2_cand_r;

  logic hold;
  logic adv;

  // The whole pipeline moves together. It stops only when a result is due to
  // enter the output register while the previous result is still refused.
  assign hold     = s2_ctl_r.vld & s2_ctl_r.last & out_valid & out_stall;
  assign adv      = ~hold;
  assign in_stall = hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r <= '0;
    end else if (adv) begin
      s0_ctl_r.vld      <= in_valid;
      s0_ctl_r.last     <= in_last;
      s0_ctl_r.use_cand <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s0_value_r <= in_value;
    end
  end

  mels_prefix #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_prefix (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_in (s0_ctl_r),
    .value  (s0_value_r),
    .ctl_r  (s1_ctl),
    .sum_r  (s1_sum),
    .base_r (s1_base)
  );

  // The run sum is the new prefix sum less the smallest earlier prefix sum of
  // matching parity; it wraps modulo 2^64 like every other sum here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_ctl.vld) begin
      s2_cand_r <= s1_sum - s1_base;
    end
  end

  mels_best u_best (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .ctl          (s2_ctl_r),
    .cand         (s2_cand_r),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_best_sum (out_best_sum),
    .out_found    (out_found)
  );

endmodule

// ----- tb/max_even_length_subarray_sum_tb.sv -----
module max_even_length_subarray_sum_tb;

  // Element width used for this run; the block is built with the same value.
  localparam int unsigned VW = 32;

  localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  // Fewer requests than this left to send means the tail of the run, where
  // neither side idles any more.
  localparam int TAIL_ITEMS = 150;

  // One entry of the stimulus queue. A pause entry is not sent; it holds the
  // sender back until every expected result has been checked.
  typedef struct packed {
    logic            pause;
    logic [VW-1:0]   value;
    logic            last;
  } elem_req_t;

  // What the block should report for one finished sequence.
  typedef struct packed {
    mels_pkg::sum_t best;
    logic           found;
  } run_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [VW-1:0] in_value = '0;
  logic          in_last = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic signed [63:0] out_best_sum;
  logic          out_found;

  max_even_length_subarray_sum #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value    (in_value),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_best_sum(out_best_sum),
    .out_found   (out_found)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Requests still to be sent, and results still to be checked.
  elem_req_t   elem_queue[$];
  run_result_t expected_sums[$];

  int elems_queued = 0;
  int elems_taken = 0;
  int mismatch_cnt = 0;

  // Set once the stimulus queue runs low; from then on nobody idles.
  logic tail_calm = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor state. It follows the block's own bookkeeping: the running prefix
  // sum, the last four prefix sums (newest first), the smallest prefix sum seen
  // at an even and at an odd index that may still open a run, and the best run
  // sum found so far.
  // ---------------------------------------------------------------------------
  mels_pkg::sum_t prefix_acc;
  mels_pkg::sum_t prefix_hist [mels_pkg::HIST_DEPTH];
  mels_pkg::sum_t low_even;
  mels_pkg::sum_t low_odd;
  mels_pkg::sum_t best_run;
  logic           run_seen;
  logic [2:0]     elem_count;
  logic           odd_count;

  // Back to the start of a sequence. The empty prefix counts as an even-index
  // start, so the even minimum begins at zero; no odd start exists yet.
  task automatic clear_runs();
    prefix_acc = '0;
    for (int i = 0; i < mels_pkg::HIST_DEPTH; i++) prefix_hist[i] = '0;
    low_even   = '0;
    low_odd    = mels_pkg::SUM_MAX;
    best_run   = mels_pkg::SUM_MIN;
    run_seen   = 1'b0;
    elem_count = '0;
    odd_count  = 1'b0;
  endtask

  // Folds one accepted element into the running state. From the fourth element
  // on, the prefix sum four places back becomes a legal start of a run; it is
  // merged into the minimum of its parity and the run ending here is scored
  // against that minimum. A request marked last closes the sequence.
  task automatic fold_element(input logic [VW-1:0] v, input logic is_last);
    mels_pkg::sum_t elem;
    mels_pkg::sum_t oldest;
    mels_pkg::sum_t new_sum;
    mels_pkg::sum_t cand;
    run_result_t    res;
    elem    = {{(mels_pkg::SUM_W-VW){v[VW-1]}}, v};
    oldest  = prefix_hist[mels_pkg::HIST_DEPTH-1];
    new_sum = prefix_acc + elem;
    if (elem_count >= mels_pkg::RUN_START) begin
      if (odd_count) begin
        if (oldest < low_even) low_even = oldest;
        cand = new_sum - low_even;
      end else begin
        if (oldest < low_odd) low_odd = oldest;
        cand = new_sum - low_odd;
      end
      if (!run_seen || best_run < cand) best_run = cand;
      run_seen = 1'b1;
    end
    for (int i = mels_pkg::HIST_DEPTH - 1; i > 0; i--) prefix_hist[i] = prefix_hist[i-1];
    prefix_hist[0] = new_sum;
    prefix_acc = new_sum;
    if (elem_count < mels_pkg::COUNT_SAT) elem_count = elem_count + 3'd1;
    odd_count = ~odd_count;
    if (is_last) begin
      // Sequences shorter than four elements report zero with found low.
      res.best  = run_seen ? best_run : '0;
      res.found = run_seen;
      expected_sums.push_back(res);
      clear_runs();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver. A request stays on the port until it is taken; only then may the
  // next one, a gap, or a pause take its place. Gaps come in bursts, and whole
  // stretches go by without any.
  // ---------------------------------------------------------------------------
  int        send_gap = 0;
  logic      holding = 1'b0;
  logic      send_gaps_on = 1'b1;
  elem_req_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      holding  <= 1'b0;
    end else begin
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (holding) begin
          // The last request before the pause was taken at an earlier edge,
          // so its expectation is already queued when this test is made.
          if (expected_sums.size() == 0) holding <= 1'b0;
          in_valid <= 1'b0;
        end else if (elem_queue.size() != 0 && !tail_calm && send_gaps_on &&
                     $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (elem_queue.size() != 0) begin
          next_req = elem_queue.pop_front();
          if (next_req.pause) begin
            holding  <= 1'b1;
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_value <= next_req.value;
            in_last  <= next_req.last;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 99) == 0) send_gaps_on <= ~send_gaps_on;
      tail_calm <= (elem_queue.size() < TAIL_ITEMS);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each edge it first checks a result taken at that edge against
  // the oldest expectation, then folds a request taken at that edge into the
  // predictor. A result always trails its request through the pipeline
  // registers, so this order never lets a result meet its own expectation
  // early. It also drives out_stall in bursts.
  // ---------------------------------------------------------------------------
  int          stall_left = 0;
  logic        stalls_on = 1'b1;
  run_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      clear_runs();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with none expected: best_sum %0d found %0b",
                   $time, out_best_sum, out_found);
        end else begin
          want = expected_sums.pop_front();
          if (out_best_sum !== want.best) begin
            mismatch_cnt++;
            $display("%0t: best_sum expected %0d actual %0d",
                     $time, want.best, out_best_sum);
          end
          if (out_found !== want.found) begin
            mismatch_cnt++;
            $display("%0t: found expected %0b actual %0b",
                     $time, want.found, out_found);
          end
        end
      end
      if (in_valid && !in_stall) begin
        fold_element(in_value, in_last);
        elems_taken++;
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!tail_calm && stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 17);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 99) == 0) stalls_on <= ~stalls_on;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  task automatic queue_element(input logic [VW-1:0] v, input logic is_last);
    elem_req_t r;
    r.pause = 1'b0;
    r.value = v;
    r.last  = is_last;
    elem_queue.push_back(r);
    elems_queued++;
  endtask

  task automatic queue_pause();
    elem_req_t r;
    r = '0;
    r.pause = 1'b1;
    elem_queue.push_back(r);
  endtask

  // Small values in four draws of ten so that the best run moves around, with
  // the extremes and fully random words mixed in so that every bit toggles.
  function automatic logic [VW-1:0] rand_value();
    logic [VW-1:0] small_val;
    small_val = $urandom_range(0, 400);
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3, 4, 5: return small_val - 200;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int seq_len;

    // Sequences of one, two and three elements never hold a run of four.
    queue_element(VAL_MAX, 1'b1);
    queue_element(VAL_MIN, 1'b0);
    queue_element(VAL_MAX, 1'b1);
    queue_element('1, 1'b0);
    queue_element('0, 1'b0);
    queue_element(1, 1'b1);
    // Four elements at the top extreme and five at the bottom: the largest and
    // the most negative sum a run of four can reach.
    repeat (3) queue_element(VAL_MAX, 1'b0);
    queue_element(VAL_MAX, 1'b1);
    repeat (4) queue_element(VAL_MIN, 1'b0);
    queue_element(VAL_MIN, 1'b1);
    // Alternating extremes, so that both parity minima get refreshed.
    repeat (2) begin
      queue_element(VAL_MAX, 1'b0);
      queue_element(VAL_MIN, 1'b0);
    end
    queue_element(VAL_MAX, 1'b0);
    queue_element(VAL_MIN, 1'b1);
    // A short mixed run whose best sum is negative.
    queue_element(-5, 1'b0);
    queue_element(3, 1'b0);
    queue_element(-7, 1'b0);
    queue_element(2, 1'b1);
    // Let everything drain before the random part starts.
    queue_pause();

    // Random sequences, mostly short so that many results come back, a few
    // long ones so that runs start far from the sequence start.
    while (elems_queued < 1600) begin
      if ($urandom_range(0, 9) == 0) seq_len = $urandom_range(13, 40);
      else seq_len = $urandom_range(1, 12);
      for (int k = 0; k < seq_len; k++) queue_element(rand_value(), k == seq_len - 1);
      if ($urandom_range(0, 39) == 0) queue_pause();
    end

    wait (elems_taken == elems_queued);
    wait (expected_sums.size() == 0);
    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Backstop against a hang; far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mels_pkg.sv
rtl/core/mels_prefix.sv
rtl/core/mels_best.sv
rtl/core/max_even_length_subarray_sum.sv
tb/max_even_length_subarray_sum_tb.sv
